// File: src/sasm_pkg.sv
// ----------------------------------------------------------------------------
// sasm_pkg
// Types and constants shared by the angular spring moment datapath.
// ----------------------------------------------------------------------------
package sasm_pkg;

	localparam int unsigned ColW     = 16;
	localparam int unsigned CrossW   = 52;
	localparam int unsigned MomentW  = 48;

	localparam logic [2:0] REG_REF_X = 3'd0;
	localparam logic [2:0] REG_REF_Y = 3'd1;
	localparam logic [2:0] REG_REF_Z = 3'd2;
	localparam logic [2:0] REG_STIFF = 3'd3;
	localparam logic [2:0] REG_DAMP  = 3'd4;

	localparam logic signed [MomentW-1:0] MOMENT_MAX = {1'b0, {(MomentW-1){1'b1}}};
	localparam logic signed [MomentW-1:0] MOMENT_MIN = {1'b1, {(MomentW-1){1'b0}}};

	typedef logic signed [ColW-1:0] vec3_t [3];
	typedef logic signed [CrossW-1:0] cross_t [3];

	typedef struct packed {
		logic signed [15:0] rot_xx;
		logic signed [15:0] rot_xy;
		logic signed [15:0] rot_xz;
		logic signed [15:0] rot_yx;
		logic signed [15:0] rot_yy;
		logic signed [15:0] rot_yz;
		logic signed [15:0] rot_zx;
		logic signed [15:0] rot_zy;
		logic signed [15:0] rot_zz;
		logic signed [31:0] spin_x;
		logic signed [31:0] spin_y;
		logic signed [31:0] spin_z;
	} body_state_t;

	typedef struct packed {
		logic signed [47:0] moment_x;
		logic signed [47:0] moment_y;
		logic signed [47:0] moment_z;
	} moment_t;

	function automatic vec3_t unpack_col(input logic [47:0] packed_col);
		vec3_t v;
		for (int i = 0; i < 3; i++) begin
			v[i] = packed_col[16*i +: 16];
		end
		return v;
	endfunction

endpackage

// File: src/spherical_angular_spring_moment.sv
// ----------------------------------------------------------------------------
// spherical_angular_spring_moment
// Restoring moment of a damped spherical angular spring on a rigid body.
// ----------------------------------------------------------------------------
// Usage:
//   Drive a body state on state_in and raise start; it is taken at every
//   rising edge where start is high (busy is always low). Three axis lanes
//   work side by side, one per reference column, and a merge stage sums
//   their cross products and applies stiffness and damping.
//   The moment appears on result with done high for exactly one cycle.
//   Throughput is one item per cycle, set by the six-stage pipeline.
//   The receiver cannot stall; each result is presented once.
//   Registers are written through wr_en / wr_index / wr_data; the user must
//   write them only while the pipeline is empty, which the block does not
//   enforce; unknown indices are dropped.
//   Reset clears the pipeline valid bits and restores the identity reference
//   with zero stiffness and damping.
// ----------------------------------------------------------------------------
module spherical_angular_spring_moment
	import sasm_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	output logic        busy,
	input  body_state_t state_in,
	input  logic        wr_en,
	input  logic [2:0]  wr_index,
	input  logic [47:0] wr_data,
	output logic        done,
	output moment_t     result
);

	logic [47:0] ref_x_q, ref_y_q, ref_z_q;
	logic [31:0] stiff_q, damp_q;
	logic [5:0]  valid_q;
	vec3_t       cx, cy, cz, nx, ny, nz;
	cross_t      cr0, cr1, cr2;
	logic signed [31:0] spin [3];

	assign busy = 1'b0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ref_x_q <= 48'd16384;
			ref_y_q <= 48'd16384 << 16;
			ref_z_q <= 48'd16384 << 32;
			stiff_q <= '0;
			damp_q  <= '0;
		end else if (wr_en) begin
			case (wr_index)
				REG_REF_X: ref_x_q <= wr_data;
				REG_REF_Y: ref_y_q <= wr_data;
				REG_REF_Z: ref_z_q <= wr_data;
				REG_STIFF: stiff_q <= wr_data[31:0];
				REG_DAMP:  damp_q  <= wr_data[31:0];
				default: ;
			endcase
		end
	end

	// advance the valid bit alongside the payload
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
		end else begin
			valid_q <= {valid_q[4:0], start & ~busy};
		end
	end

	assign done = valid_q[5];

	always_comb begin
		cx = unpack_col(ref_x_q);
		cy = unpack_col(ref_y_q);
		cz = unpack_col(ref_z_q);
		nx = '{state_in.rot_xx, state_in.rot_yx, state_in.rot_zx};
		ny = '{state_in.rot_xy, state_in.rot_yy, state_in.rot_zy};
		nz = '{state_in.rot_xz, state_in.rot_yz, state_in.rot_zz};
		spin = '{state_in.spin_x, state_in.spin_y, state_in.spin_z};
	end

	sasm_lane u_lane0 (.clk(clk), .ref_a(cx), .ref_r(cy), .col_n(ny), .cross_s3(cr0));
	sasm_lane u_lane1 (.clk(clk), .ref_a(cy), .ref_r(cz), .col_n(nz), .cross_s3(cr1));
	sasm_lane u_lane2 (.clk(clk), .ref_a(cz), .ref_r(cx), .col_n(nx), .cross_s3(cr2));

	sasm_merge u_merge (
		.clk       (clk),
		.cross0_s3 (cr0),
		.cross1_s3 (cr1),
		.cross2_s3 (cr2),
		.spin      (spin),
		.stiffness (stiff_q),
		.damping   (damp_q),
		.moment_s6 (result)
	);

endmodule

// File: src/sasm_lane.sv
// ----------------------------------------------------------------------------
// sasm_lane
// One axis: projects an orientation column off a reference column and
// crosses the remainder with the next reference column. Three stages.
// ----------------------------------------------------------------------------
module sasm_lane
	import sasm_pkg::*;
(
	input  logic   clk,
	input  vec3_t  ref_a,
	input  vec3_t  ref_r,
	input  vec3_t  col_n,
	output cross_t cross_s3
);

	logic signed [32:0] dot_s1;
	vec3_t              n_s1;
	logic signed [34:0] p_s2 [3];

	always_ff @(posedge clk) begin
		dot_s1 <= 33'(ref_a[0] * col_n[0]) + 33'(ref_a[1] * col_n[1])
			+ 33'(ref_a[2] * col_n[2]);
		n_s1   <= col_n;
	end

	// round the Q42 remainder to Q28, ties upward
	always_ff @(posedge clk) begin
		for (int i = 0; i < 3; i++) begin
			p_s2[i] <= 35'(((49'(n_s1[i]) <<< 28) - 49'(dot_s1 * ref_a[i])
				+ 49'sd8192) >>> 14);
		end
	end

	always_ff @(posedge clk) begin
		cross_s3[0] <= CrossW'(51'(ref_r[1] * p_s2[2]) - 51'(ref_r[2] * p_s2[1]));
		cross_s3[1] <= CrossW'(51'(ref_r[2] * p_s2[0]) - 51'(ref_r[0] * p_s2[2]));
		cross_s3[2] <= CrossW'(51'(ref_r[0] * p_s2[1]) - 51'(ref_r[1] * p_s2[0]));
	end

endmodule

// File: src/sasm_merge.sv
// ----------------------------------------------------------------------------
// sasm_merge
// Sums the lane cross products, applies stiffness and damping, saturates.
// ----------------------------------------------------------------------------
module sasm_merge
	import sasm_pkg::*;
(
	input  logic        clk,
	input  cross_t      cross0_s3,
	input  cross_t      cross1_s3,
	input  cross_t      cross2_s3,
	input  logic signed [31:0] spin [3],
	input  logic [31:0] stiffness,
	input  logic [31:0] damping,
	output moment_t     moment_s6
);

	logic signed [31:0] spin_s1 [3];
	logic signed [31:0] spin_s2 [3];
	logic signed [31:0] spin_s3 [3];
	logic signed [27:0] s_s4 [3];
	logic signed [64:0] dprod_s4 [3];
	logic signed [61:0] kprod_s5 [3];
	logic signed [49:0] damp_s5 [3];
	logic signed [47:0] m_sat [3];
	logic signed [53:0] acc [3];
	logic signed [50:0] m_full [3];
	logic signed [45:0] spring [3];

	always_ff @(posedge clk) begin
		spin_s1 <= spin;
		spin_s2 <= spin_s1;
		spin_s3 <= spin_s2;
	end

	always_comb begin
		for (int i = 0; i < 3; i++) begin
			acc[i] = 54'(cross0_s3[i]) + 54'(cross1_s3[i]) + 54'(cross2_s3[i]);
		end
	end

	always_ff @(posedge clk) begin
		for (int i = 0; i < 3; i++) begin
			s_s4[i]     <= 28'((acc[i] + 54'sd33554432) >>> 26);
			dprod_s4[i] <= $signed({1'b0, damping}) * spin_s3[i];
			kprod_s5[i] <= 62'($signed({1'b0, stiffness}) * s_s4[i]);
			damp_s5[i]  <= 50'((-66'(dprod_s4[i]) + 66'sd32768) >>> 16);
		end
	end

	always_comb begin
		for (int i = 0; i < 3; i++) begin
			spring[i] = 46'((-63'(kprod_s5[i]) + 63'sd32768) >>> 16);
			m_full[i] = 51'(spring[i]) + 51'(damp_s5[i]);
			if (m_full[i] > 51'(MOMENT_MAX)) begin
				m_sat[i] = MOMENT_MAX;
			end else if (m_full[i] < 51'(MOMENT_MIN)) begin
				m_sat[i] = MOMENT_MIN;
			end else begin
				m_sat[i] = m_full[i][47:0];
			end
		end
	end

	always_ff @(posedge clk) begin
		moment_s6.moment_x <= m_sat[0];
		moment_s6.moment_y <= m_sat[1];
		moment_s6.moment_z <= m_sat[2];
	end

endmodule

// File: src/sasm_checker.sv
// ----------------------------------------------------------------------------
// sasm_checker
// Port-level checks on the transfer timing of the moment pipeline.
// ----------------------------------------------------------------------------
module sasm_checker (
	input logic clk,
	input logic arst_n,
	input logic start,
	input logic busy,
	input logic done
);

	a_accept_gives_done: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |-> ##6 done) else $error("missing result");

	a_done_has_source: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(start && !busy, 6)) else $error("spurious result");

	a_quiet_after_reset: assert property (@(posedge clk)
		$rose(arst_n) |-> !done) else $error("result straight after reset");

endmodule

bind spherical_angular_spring_moment sasm_checker u_sasm_checker (
	.clk(clk), .arst_n(arst_n), .start(start), .busy(busy), .done(done)
);

// File: tb/sv/spherical_angular_spring_moment_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// spherical_angular_spring_moment_tb
// Drives body states through the spring moment block under several register
// settings, predicts each moment in fixed point and checks every transfer.
// ----------------------------------------------------------------------------
module spherical_angular_spring_moment_tb;
	import sasm_pkg::*;

	logic        clk;
	logic        arst_n;
	logic        start;
	logic        busy;
	body_state_t state_in;
	logic        wr_en;
	logic [2:0]  wr_index;
	logic [47:0] wr_data;
	logic        done;
	moment_t     result;

	logic [47:0] ref_col [3];
	logic [31:0] stiffness;
	logic [31:0] damping;
	moment_t     pending_moments [$];
	int          fail_count;
	int          send_idle_pct;

	spherical_angular_spring_moment DUT (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy),
		.state_in(state_in), .wr_en(wr_en), .wr_index(wr_index),
		.wr_data(wr_data), .done(done), .result(result)
	);

	always begin
		clk = 1'b0; #4;
		clk = 1'b1; #4;
	end

	// Round x / 2^s to nearest, ties toward plus infinity (arithmetic shift floors).
	function automatic logic signed [127:0] round_sh(input logic signed [127:0] x, input int s);
		logic signed [127:0] y;
		y = x + (128'sd1 <<< (s - 1));
		return y >>> s;
	endfunction

	function automatic moment_t spring_moment(input body_state_t b);
		logic signed [15:0] rot [3][3];
		logic signed [15:0] rc [3][3];
		logic signed [127:0] acc [3];
		logic signed [127:0] n [3];
		logic signed [127:0] p [3];
		logic signed [127:0] dotp, s, w, m;
		logic signed [47:0] mo [3];
		moment_t res;
		int nc;
		rot[0][0] = b.rot_xx; rot[0][1] = b.rot_xy; rot[0][2] = b.rot_xz;
		rot[1][0] = b.rot_yx; rot[1][1] = b.rot_yy; rot[1][2] = b.rot_yz;
		rot[2][0] = b.rot_zx; rot[2][1] = b.rot_zy; rot[2][2] = b.rot_zz;
		for (int c = 0; c < 3; c++)
			for (int i = 0; i < 3; i++)
				rc[c][i] = ref_col[c][16*i +: 16];
		for (int i = 0; i < 3; i++)
			acc[i] = 0;
		for (int c = 0; c < 3; c++) begin
			nc = (c + 1) % 3;
			dotp = 0;
			for (int i = 0; i < 3; i++) begin
				n[i] = rot[i][nc];
				dotp += rc[c][i] * n[i];
			end
			for (int i = 0; i < 3; i++)
				p[i] = round_sh((n[i] <<< 28) - dotp * rc[c][i], 14);
			acc[0] += rc[nc][1] * p[2] - rc[nc][2] * p[1];
			acc[1] += rc[nc][2] * p[0] - rc[nc][0] * p[2];
			acc[2] += rc[nc][0] * p[1] - rc[nc][1] * p[0];
		end
		for (int i = 0; i < 3; i++) begin
			s = round_sh(acc[i], 26);
			w = (i == 0) ? b.spin_x : (i == 1) ? b.spin_y : b.spin_z;
			m = round_sh(-($signed({96'd0, stiffness}) * s), 16)
				+ round_sh(-($signed({96'd0, damping}) * w), 16);
			if (m > MOMENT_MAX)
				m = MOMENT_MAX;
			else if (m < MOMENT_MIN)
				m = MOMENT_MIN;
			mo[i] = m[47:0];
		end
		res.moment_x = mo[0];
		res.moment_y = mo[1];
		res.moment_z = mo[2];
		return res;
	endfunction

	// Leaves start high; whoever stops sending drops it.
	task automatic send_state(input body_state_t b);
		while ($urandom_range(99) < send_idle_pct) begin
			start <= 1'b0;
			@(negedge clk);
		end
		start    <= 1'b1;
		state_in <= b;
		@(posedge clk);
		while (busy)
			@(posedge clk);
		pending_moments.push_back(spring_moment(b));
		@(negedge clk);
	endtask

	// Only call while idle; drain the pipeline first.
	task automatic write_reg(input logic [2:0] idx, input logic [47:0] val);
		start <= 1'b0;
		while (pending_moments.size() != 0)
			@(negedge clk);
		repeat (8) @(negedge clk);
		wr_en    <= 1'b1;
		wr_index <= idx;
		wr_data  <= val;
		case (idx)
			REG_REF_X: ref_col[0] = val;
			REG_REF_Y: ref_col[1] = val;
			REG_REF_Z: ref_col[2] = val;
			REG_STIFF: stiffness = val[31:0];
			REG_DAMP:  damping = val[31:0];
			default: ;
		endcase
		@(negedge clk);
		wr_en <= 1'b0;
	endtask

	function automatic logic [15:0] rand_entry();
		case ($urandom_range(5))
			0: return 16'h4000;
			1: return 16'hC000;
			2: return 16'd0;
			3: return 16'($urandom);
			default: return 16'($signed($urandom_range(32768)) - 16384);
		endcase
	endfunction

	function automatic logic [31:0] rand_spin();
		case ($urandom_range(4))
			0: return 32'h7FFFFFFF;
			1: return 32'h80000000;
			2: return $urandom_range(131072) - 65536;
			default: return $urandom;
		endcase
	endfunction

	function automatic body_state_t rand_state();
		body_state_t b;
		b.rot_xx = rand_entry(); b.rot_xy = rand_entry(); b.rot_xz = rand_entry();
		b.rot_yx = rand_entry(); b.rot_yy = rand_entry(); b.rot_yz = rand_entry();
		b.rot_zx = rand_entry(); b.rot_zy = rand_entry(); b.rot_zz = rand_entry();
		b.spin_x = rand_spin(); b.spin_y = rand_spin(); b.spin_z = rand_spin();
		return b;
	endfunction

	function automatic logic [47:0] pack_col(input int a, input int b, input int c);
		return {16'(c), 16'(b), 16'(a)};
	endfunction

	task automatic test_directed();
		body_state_t b;
		logic [15:0] ext [4];
		ext[0] = 16'h4000; ext[1] = 16'hC000; ext[2] = 16'h7FFF; ext[3] = 16'h8000;
		write_reg(REG_STIFF, 48'h0001_0000);
		write_reg(REG_DAMP, 48'h0000_8000);
		// identity orientation, zero spin
		b = '0;
		b.rot_xx = 16'h4000; b.rot_yy = 16'h4000; b.rot_zz = 16'h4000;
		send_state(b);
		for (int i = 0; i < 4; i++) begin
			b = {{9{ext[i]}}, 32'h7FFFFFFF, 32'h80000000, 32'hFFFFFFFF};
			send_state(b);
		end
		b = {144'd0, 32'h80000000, 32'h7FFFFFFF, 32'h00000001};
		send_state(b);
		// saturation at extreme gains
		write_reg(REG_STIFF, 48'hFFFF_FFFF);
		write_reg(REG_DAMP, 48'hFFFF_FFFF);
		for (int i = 0; i < 4; i++) begin
			b = {ext[i], ext[(i+1)%4], ext[(i+2)%4], ext[(i+3)%4], ext[i],
				ext[(i+1)%4], ext[(i+2)%4], ext[(i+3)%4], ext[i],
				32'h80000000, 32'h7FFFFFFF, 32'h80000000};
			send_state(b);
		end
		// reference not a rotation, plus two ignored indices
		write_reg(REG_REF_X, 48'h8000_7FFF_C000);
		write_reg(REG_REF_Y, 48'hFFFF_FFFF_FFFF);
		write_reg(REG_REF_Z, 48'h7FFF_8000_0000);
		write_reg(3'd7, 48'hFFFF_FFFF_FFFF);
		write_reg(3'd5, 48'h0);
		for (int i = 0; i < 8; i++)
			send_state(rand_state());
	endtask

	task automatic test_random(input int count);
		for (int phase = 0; phase < 3; phase++) begin
			send_idle_pct = (phase == 0) ? 26 : (phase == 1) ? 48 : 0;
			case ($urandom_range(3))
				0: begin
					write_reg(REG_REF_X, pack_col(16384, 0, 0));
					write_reg(REG_REF_Y, pack_col(0, 16384, 0));
					write_reg(REG_REF_Z, pack_col(0, 0, 16384));
				end
				1: begin
					write_reg(REG_REF_X, pack_col(0, 16384, 0));
					write_reg(REG_REF_Y, pack_col(-16384, 0, 0));
					write_reg(REG_REF_Z, pack_col(0, 0, 16384));
				end
				default: begin
					write_reg(REG_REF_X, 48'({$urandom, $urandom}));
					write_reg(REG_REF_Y, 48'({$urandom, $urandom}));
					write_reg(REG_REF_Z, 48'({$urandom, $urandom}));
				end
			endcase
			write_reg(REG_STIFF, (phase == 2) ? 48'hFFFF_FFFF : 48'($urandom_range(262144)));
			write_reg(REG_DAMP, (phase == 2) ? 48'h0 : 48'($urandom));
			for (int i = 0; i < count; i++)
				send_state(rand_state());
		end
	endtask

	always @(posedge clk) begin
		moment_t exp_m;
		if (arst_n && done) begin
			if (pending_moments.size() == 0) begin
				$display("%0t: unexpected moment %h", $time, result);
				fail_count++;
			end else begin
				exp_m = pending_moments.pop_front();
				if (result.moment_x !== exp_m.moment_x) begin
					$display("%0t: moment_x expected %h actual %h", $time,
						exp_m.moment_x, result.moment_x);
					fail_count++;
				end
				if (result.moment_y !== exp_m.moment_y) begin
					$display("%0t: moment_y expected %h actual %h", $time,
						exp_m.moment_y, result.moment_y);
					fail_count++;
				end
				if (result.moment_z !== exp_m.moment_z) begin
					$display("%0t: moment_z expected %h actual %h", $time,
						exp_m.moment_z, result.moment_z);
					fail_count++;
				end
			end
		end
	end

	initial begin
		#2_000_000;
		$display("CHECKS FAILED");
		$finish;
	end

	initial begin
		arst_n = 1'b0;
		start = 1'b0;
		state_in = '0;
		wr_en = 1'b0;
		wr_index = '0;
		wr_data = '0;
		fail_count = 0;
		send_idle_pct = 0;
		ref_col[0] = 48'h4000;
		ref_col[1] = 48'h4000 << 16;
		ref_col[2] = 48'h4000 << 32;
		stiffness = '0;
		damping = '0;
		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);
		send_state(rand_state());
		test_directed();
		test_random(175);
		start <= 1'b0;
		while (pending_moments.size() != 0)
			@(negedge clk);
		repeat (12) @(negedge clk);
		if (fail_count == 0)
			$display("ALL CHECKS PASSED");
		else
			$display("CHECKS FAILED");
		$finish;
	end

endmodule
